### sv/ctf_pkg.sv
// ----------------------------------------------------------------------------
// ctf_pkg
// shared types, widths and constants of the complementary tilt filter
// ----------------------------------------------------------------------------
`default_nettype none

package ctf_pkg;

   localparam int DATA_W   = 16;
   localparam int STEPS    = 16;
   localparam int STEP_W   = $clog2(STEPS);
   localparam int CORDIC_W = 34;
   localparam int Z_W      = 25;
   localparam int GYRO_W   = 34;
   localparam int ACC_W    = 34;
   localparam int BLEND_W  = 52;
   localparam int RES_W    = BLEND_W - 32;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   localparam logic [DATA_W-1:0] BLEND_WEIGHT_RESET = 16'd64225;
   localparam logic [DATA_W-1:0] GYRO_GAIN_RESET    = 16'd1280;

   // 90 degrees in 1/32768 degree
   localparam logic signed [Z_W-1:0] Z_QUARTER = 25'sd2949120;

   typedef struct packed {
      logic signed [DATA_W-1:0] accel_x;
      logic signed [DATA_W-1:0] accel_y;
      logic signed [DATA_W-1:0] accel_z;
      logic signed [DATA_W-1:0] gyro_x;
      logic signed [DATA_W-1:0] gyro_y;
   } ctf_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] pitch_out;
      logic signed [DATA_W-1:0] roll_out;
   } ctf_rsp_type;

   typedef enum logic {
      CSR_BLEND_WEIGHT = 1'b0,
      CSR_GYRO_GAIN    = 1'b1
   } ctf_csr_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_ITER  = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_MUL   = 5'b01000,
      ST_SUM   = 5'b10000
   } ctf_state_type;

   typedef struct packed {
      logic              load;
      logic              iterate;
      logic [STEP_W-1:0] step;
      logic              round;
      logic              mult;
      logic              sum;
   } ctf_cmd_type;

   // atan(2^-i) in 1/32768 degree
   function automatic logic [Z_W-1:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [Z_W-1:0] v;
      case (idx)
         4'd0:    v = 25'd1474560;
         4'd1:    v = 25'd870484;
         4'd2:    v = 25'd459940;
         4'd3:    v = 25'd233473;
         4'd4:    v = 25'd117189;
         4'd5:    v = 25'd58652;
         4'd6:    v = 25'd29333;
         4'd7:    v = 25'd14667;
         4'd8:    v = 25'd7334;
         4'd9:    v = 25'd3667;
         4'd10:   v = 25'd1833;
         4'd11:   v = 25'd917;
         4'd12:   v = 25'd458;
         4'd13:   v = 25'd229;
         4'd14:   v = 25'd115;
         4'd15:   v = 25'd57;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### sv/ctf_cordic.sv
// ----------------------------------------------------------------------------
// ctf_cordic
// one vectoring cordic lane, one micro-rotation per cycle, rounded angle out
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_cordic (
   input  wire                                 clock,
   input  wire  ctf_pkg::ctf_cmd_type          cmd,
   input  wire  logic signed [ctf_pkg::DATA_W-1:0] arg_y,
   input  wire  logic signed [ctf_pkg::DATA_W-1:0] arg_x,
   output logic signed [ctf_pkg::DATA_W-1:0]   angle
);
   import ctf_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CORDIC_W-1:0] xs, ys, dx, dy;
   logic signed [Z_W-1:0]      z_ff, z_in, at, zr, zsh;
   logic                       zero_ff, zero_in;
   logic signed [DATA_W-1:0]   angle_ff, angle_in;

   // arguments scaled by 2^14
   assign xs = $signed({{(CORDIC_W-DATA_W){arg_x[DATA_W-1]}}, arg_x}) <<< 14;
   assign ys = $signed({{(CORDIC_W-DATA_W){arg_y[DATA_W-1]}}, arg_y}) <<< 14;
   assign dx = y_ff >>> cmd.step;
   assign dy = x_ff >>> cmd.step;
   assign at = $signed(atan_entry(cmd.step));
   assign zr = z_ff + Z_W'(128);
   assign zsh = zr >>> 8;

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      zero_in  = zero_ff;
      angle_in = angle_ff;
      if (cmd.load) begin
         zero_in = (arg_x == '0) && (arg_y == '0);
         if (xs < 0) begin
            // pre-rotate into the right half plane
            if (ys >= 0) begin
               x_in = ys;
               y_in = -xs;
               z_in = Z_QUARTER;
            end else begin
               x_in = -ys;
               y_in = xs;
               z_in = -Z_QUARTER;
            end
         end else begin
            x_in = xs;
            y_in = ys;
            z_in = '0;
         end
      end else if (cmd.iterate) begin
         if (y_ff >= 0) begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end else begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end
      end
      if (cmd.round) begin
         angle_in = zero_ff ? '0 : zsh[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      z_ff     <= z_in;
      zero_ff  <= zero_in;
      angle_ff <= angle_in;
   end

   assign angle = angle_ff;

endmodule

`default_nettype wire

### sv/ctf_datapath.sv
// ----------------------------------------------------------------------------
// ctf_datapath
// gyro integration, two cordic lanes, weighted blend and angle state
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  wire  ctf_pkg::ctf_cmd_type         cmd,
   input  wire  ctf_pkg::ctf_req_type         req_data,
   input  wire  logic [ctf_pkg::DATA_W-1:0]   blend_weight,
   input  wire  logic [ctf_pkg::DATA_W-1:0]   gyro_step_gain,
   output ctf_pkg::ctf_rsp_type               rsp_data
);
   import ctf_pkg::*;

   logic signed [DATA_W-1:0]  pitch_ff, pitch_in, roll_ff, roll_in;
   logic signed [DATA_W-1:0]  pitch_acc, roll_acc;
   logic signed [DATA_W:0]    gain_s, weight_s;
   logic signed [DATA_W+1:0]  comp_w;
   logic signed [GYRO_W-1:0]  pitch_prod, roll_prod, pitch_base, roll_base;
   logic signed [GYRO_W-1:0]  pitch_gyro_ff, roll_gyro_ff;
   logic signed [BLEND_W-1:0] pitch_gw_ff, roll_gw_ff;
   logic signed [ACC_W-1:0]   pitch_aw_ff, roll_aw_ff;

   function automatic logic signed [DATA_W-1:0] blend_round(
      input logic signed [BLEND_W-1:0] gw,
      input logic signed [ACC_W-1:0]   aw
   );
      logic signed [BLEND_W-1:0] s;
      logic signed [RES_W-1:0]   r;
      logic signed [DATA_W-1:0]  q;
      s = gw + $signed({aw, 16'b0}) + $signed(BLEND_W'(64'h8000_0000));
      r = s[BLEND_W-1:32];
      if (r > $signed(RES_W'(32767))) begin
         q = 16'sh7fff;
      end else if (r < -$signed(RES_W'(32768))) begin
         q = 16'sh8000;
      end else begin
         q = r[DATA_W-1:0];
      end
      return q;
   endfunction

   ctf_cordic u_pitch_lane (
      .clock (clock),
      .cmd   (cmd),
      .arg_y (req_data.accel_y),
      .arg_x (req_data.accel_z),
      .angle (pitch_acc)
   );

   ctf_cordic u_roll_lane (
      .clock (clock),
      .cmd   (cmd),
      .arg_y (req_data.accel_x),
      .arg_x (req_data.accel_z),
      .angle (roll_acc)
   );

   assign gain_s   = $signed({1'b0, gyro_step_gain});
   assign weight_s = $signed({1'b0, blend_weight});
   assign comp_w   = $signed(18'h10000) - $signed({2'b00, blend_weight});

   // gyro path in q16 of 1/128 degree
   assign pitch_prod = $signed(req_data.gyro_x) * gain_s;
   assign roll_prod  = $signed(req_data.gyro_y) * gain_s;
   assign pitch_base = $signed({{(GYRO_W-DATA_W-16){pitch_ff[DATA_W-1]}}, pitch_ff, 16'b0});
   assign roll_base  = $signed({{(GYRO_W-DATA_W-16){roll_ff[DATA_W-1]}}, roll_ff, 16'b0});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pitch_gyro_ff <= pitch_base + pitch_prod;
         roll_gyro_ff  <= roll_base - roll_prod;
      end
      if (cmd.round) begin
         pitch_gw_ff <= pitch_gyro_ff * weight_s;
         roll_gw_ff  <= roll_gyro_ff * weight_s;
      end
      if (cmd.mult) begin
         pitch_aw_ff <= pitch_acc * comp_w;
         roll_aw_ff  <= roll_acc * comp_w;
      end
   end

   always_comb begin
      pitch_in = pitch_ff;
      roll_in  = roll_ff;
      if (cmd.sum) begin
         pitch_in = blend_round(pitch_gw_ff, pitch_aw_ff);
         roll_in  = blend_round(roll_gw_ff, roll_aw_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= '0;
         roll_ff  <= '0;
      end else begin
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
      end
   end

   // the angle state doubles as the result register
   assign rsp_data.pitch_out = pitch_ff;
   assign rsp_data.roll_out  = roll_ff;

endmodule

`default_nettype wire

### sv/ctf_ctrl.sv
// ----------------------------------------------------------------------------
// ctf_ctrl
// sequencer: load, cordic steps, round, multiply, sum, result handshake
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_ctrl (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output ctf_pkg::ctf_cmd_type  cmd
);
   import ctf_pkg::*;

   ctf_state_type     state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      cmd.step     = step_ff;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_ITER;
            end
         end
         ST_ITER: begin
            cmd.iterate = 1'b1;
            if (step_ff == STEP_W'(STEPS-1)) begin
               state_in = ST_ROUND;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = ST_MUL;
         end
         ST_MUL: begin
            cmd.mult = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.sum      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/complementary_tilt_filter_core.sv
// ----------------------------------------------------------------------------
// complementary_tilt_filter_core
// pitch and roll complementary filter: gyro integration blended with
// accelerometer atan2 angles, fixed point, 1/128 degree outputs
// ----------------------------------------------------------------------------
//
//   channel   ports                      moves
//   req       req_valid/ready/data       one raw imu sample per transaction
//   rsp       rsp_valid/ready/data       filtered pitch and roll per transaction
//   csr       csr_psel..csr_prdata       apb registers: weight (0x0), gain (0x4)
//
// - one sample passes through: the accept cycle loads the lanes, then 16
//   cordic micro-rotations, round, multiply, sum; rsp_valid is registered
//   from the sum step
// - req_ready is high only while the sequencer is idle; a finished result may
//   wait in the result register while the next sample is accepted
// - a stalled result holds the sum step until rsp is taken
// - synchronous active-high reset clears the angle state, handshake and
//   registers (weight 64225, gain 1280)
// ----------------------------------------------------------------------------
`default_nettype none

module complementary_tilt_filter_core (
   input  wire                                clock,
   input  wire                                reset,
   // sample channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  ctf_pkg::ctf_req_type         req_data,
   // result channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output ctf_pkg::ctf_rsp_type               rsp_data,
   // register port
   input  wire                                csr_psel,
   input  wire                                csr_penable,
   input  wire                                csr_pwrite,
   input  wire  logic [ctf_pkg::CSR_AW-1:0]   csr_paddr,
   input  wire  logic [ctf_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [ctf_pkg::CSR_DW-1:0]         csr_prdata,
   output logic                               csr_pready
);
   import ctf_pkg::*;

   ctf_cmd_type       cmd;
   ctf_csr_type       csr_index;
   logic              csr_write;
   logic [DATA_W-1:0] weight_ff, weight_in;
   logic [DATA_W-1:0] gain_ff, gain_in;

   // register file: word index from address bit 2, upper data bits dropped
   assign csr_index  = ctf_csr_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      weight_in = weight_ff;
      gain_in   = gain_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_BLEND_WEIGHT: weight_in = csr_pwdata[DATA_W-1:0];
            CSR_GYRO_GAIN:    gain_in   = csr_pwdata[DATA_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_BLEND_WEIGHT: csr_prdata = {{(CSR_DW-DATA_W){1'b0}}, weight_ff};
         CSR_GYRO_GAIN:    csr_prdata = {{(CSR_DW-DATA_W){1'b0}}, gain_ff};
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= BLEND_WEIGHT_RESET;
         gain_ff   <= GYRO_GAIN_RESET;
      end else begin
         weight_ff <= weight_in;
         gain_ff   <= gain_in;
      end
   end

   // sequencer
   ctf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic and angle state; lanes sample req_data on the load command
   ctf_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_data       (req_data),
      .blend_weight   (weight_ff),
      .gyro_step_gain (gain_ff),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

### sv/ctf_checker.sv
// ----------------------------------------------------------------------------
// ctf_checker
// port-level checks of the tilt filter handshakes
// ----------------------------------------------------------------------------
`default_nettype none

module ctf_checker (
   input wire                  clock,
   input wire                  reset,
   input wire                  req_valid,
   input wire                  req_ready,
   input wire                  rsp_valid,
   input wire                  rsp_ready,
   input wire ctf_pkg::ctf_rsp_type rsp_data
);
   import ctf_pkg::*;

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   // one sample in flight
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while busy");

   // a new result shows up just as the sequencer returns to idle
   a_rsp_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready && !$past(req_ready))
      else $error("result appeared outside end of processing");

   // reset leaves an empty, ready block
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("bad state after reset");

endmodule

bind complementary_tilt_filter_core ctf_checker u_ctf_checker (.*);

`default_nettype wire
